// File: rtl/mco_pkg.sv
// Shared constants for the midpoint circle outline generator.
// No dependencies; imported by every module of the block.
package mco_pkg;

	// Width of the radius register and its value after reset
	localparam int unsigned RAD_W        = 6;
	localparam logic [RAD_W-1:0] RAD_RESET = 6'd20;

	// Default parameter values for the top level
	localparam int unsigned MAX_RADIUS_DEF = 32;
	localparam int unsigned COORD_BITS_DEF = 13;

	// A circle produces at most this many output words
	localparam int unsigned MAX_RESULTS = 52;
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

	// Depth of the job queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

endpackage

// File: rtl/mco_front.sv
// Front end: radius register, centre intake, radius clamp and a short job queue.
// Depends on mco_pkg.
module mco_front import mco_pkg::*; #(
	parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned OFF_BITS   = $clog2(MAX_RADIUS + 2),
	parameter int unsigned JOB_W      = 2 * COORD_BITS + OFF_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    radius_we,
	input  logic [RAD_W-1:0]        radius_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   in_cx,
	input  logic [COORD_BITS-1:0]   in_cy,
	output logic                    job_valid,
	input  logic                    job_pop,
	output logic [JOB_W-1:0]        job_data    // {radius, cy, cx}
);

	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	logic [RAD_W-1:0]    radius_q;
	logic [OFF_BITS-1:0] rad_clamped;
	logic [JOB_W-1:0]    queue_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   fill_q;
	logic                push;
	logic                pop;

	// Radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_RESET;
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	// Clamp radius into 1..MAX_RADIUS
	always_comb begin
		if (radius_q == '0) begin
			rad_clamped = OFF_BITS'(1);
		end else if (32'(radius_q) > MAX_RADIUS) begin
			rad_clamped = OFF_BITS'(MAX_RADIUS);
		end else begin
			rad_clamped = OFF_BITS'(radius_q);
		end
	end

	assign in_ready  = (fill_q != QCNT_W'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign pop       = job_pop && job_valid;
	assign job_valid = (fill_q != '0);
	assign job_data  = queue_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= {rad_clamped, in_cy, in_cx};
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/mco_back.sv
// Back end: midpoint circle tracer, point mirroring with saturation, output register.
// Depends on mco_pkg.
module mco_back import mco_pkg::*; #(
	parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned OFF_BITS   = $clog2(MAX_RADIUS + 2),
	parameter int unsigned JOB_W      = 2 * COORD_BITS + OFF_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_pop,
	input  logic [JOB_W-1:0]          job_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [8*COORD_BITS-1:0]   out_points,   // px0,py0,px1,py1,px2,py2,px3,py3
	output logic                      out_swapped,
	output logic                      out_last
);

	localparam int unsigned DEC_W = OFF_BITS + 4;
	localparam int unsigned SUM_W = COORD_BITS + 1;

	typedef logic signed [DEC_W-1:0] dec_t;

	logic                       busy_q;
	logic [OFF_BITS-1:0]        x_q;
	logic [OFF_BITS-1:0]        y_q;
	dec_t                       d_q;
	logic                       half_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [COORD_BITS-1:0]      cx_q;
	logic [COORD_BITS-1:0]      cy_q;

	logic                       advance;
	logic [OFF_BITS-1:0]        off_a;
	logic [OFF_BITS-1:0]        off_b;
	logic [COORD_BITS-1:0]      cx_pa, cx_ma, cy_pb, cy_mb;
	logic                       cap_hit;
	logic                       word_last;
	dec_t                       xe, ye, d_next, d_init;
	logic [OFF_BITS-1:0]        job_r;

	// Saturating centre +/- offset
	function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] c,
			input logic [OFF_BITS-1:0] off, input logic sub);
		logic [SUM_W-1:0] ce;
		logic [SUM_W-1:0] oe;
		logic [SUM_W-1:0] s;
		ce = {c[COORD_BITS-1], c};
		oe = {{(SUM_W-OFF_BITS){1'b0}}, off};
		s  = sub ? (ce - oe) : (ce + oe);
		if (s[SUM_W-1] != s[SUM_W-2]) begin
			sat_add = s[SUM_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
			                     : {1'b0, {(COORD_BITS-1){1'b1}}};
		end else begin
			sat_add = s[COORD_BITS-1:0];
		end
	endfunction

	assign advance = busy_q && (!out_valid || out_ready);
	assign job_pop = !busy_q && job_valid;
	assign job_r   = job_data[JOB_W-1 -: OFF_BITS];

	// Half 0 uses (x,y), half 1 the swapped (y,x)
	assign off_a = half_q ? y_q : x_q;
	assign off_b = half_q ? x_q : y_q;
	assign cx_pa = sat_add(cx_q, off_a, 1'b0);
	assign cx_ma = sat_add(cx_q, off_a, 1'b1);
	assign cy_pb = sat_add(cy_q, off_b, 1'b0);
	assign cy_mb = sat_add(cy_q, off_b, 1'b1);

	assign cap_hit   = (32'(cnt_q) == MAX_RESULTS - 1);
	assign word_last = cap_hit || (half_q && (x_q > y_q));

	// Decision update; the row offset drops first when d is positive
	assign xe     = dec_t'({{(DEC_W-OFF_BITS){1'b0}}, x_q});
	assign ye     = dec_t'({{(DEC_W-OFF_BITS){1'b0}}, y_q});
	assign d_next = (d_q > 0) ? (d_q + ((xe - ye) <<< 2) + dec_t'(14))
	                          : (d_q + (xe <<< 2) + dec_t'(6));
	assign d_init = dec_t'(3) - (dec_t'({{(DEC_W-OFF_BITS){1'b0}}, job_r}) <<< 1);

	// Tracer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			x_q    <= '0;
			y_q    <= '0;
			d_q    <= '0;
			half_q <= 1'b0;
			cnt_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			x_q    <= '0;
			y_q    <= job_r;
			d_q    <= d_init;
			half_q <= 1'b0;
			cnt_q  <= '0;
			cx_q   <= job_data[COORD_BITS-1:0];
			cy_q   <= job_data[2*COORD_BITS-1:COORD_BITS];
		end else if (advance) begin
			cnt_q <= cnt_q + 1'b1;
			if (word_last) begin
				busy_q <= 1'b0;
				half_q <= 1'b0;
			end else if (!half_q) begin
				half_q <= 1'b1;
			end else begin
				half_q <= 1'b0;
				d_q    <= d_next;
				x_q    <= x_q + 1'b1;
				if (d_q > 0) begin
					y_q <= y_q - 1'b1;
				end
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_points  <= {cy_mb, cx_ma, cy_mb, cx_pa, cy_pb, cx_ma, cy_pb, cx_pa};
			out_swapped <= half_q;
			out_last    <= word_last;
		end
	end

endmodule

// File: rtl/midpoint_circle_outline_top.sv
// Top level of the midpoint circle outline generator.
// Depends on mco_pkg, mco_front and mco_back.
// Usage:
//   Write the radius on radius_we/radius_wdata while the block is idle
//   (0 acts as 1, values above MAX_RADIUS act as MAX_RADIUS; reset value 20).
//   Each word on the s_ side is a circle center {center_y, center_x}.
//   For every center the m_ side sends two words per traced offset, the
//   first with m_tuser = 0 (points from (x,y)), the second with m_tuser = 1
//   (points from (y,x)); m_tlast marks the final word of the circle.
//   Coordinates saturate at the signed COORD_BITS range.
// Timing:
//   A center goes into a two-entry queue. On an idle block the center goes
//   from the queue into the tracer state and its first word into the output
//   register; then the m_ side sends one word per cycle while m_tready is high:
//   2*(N+1) words for N tracer steps (32 words, 15 steps at radius 20),
//   capped at 52. Between circles the tracer loads the next job from the queue,
//   and no word goes out meanwhile. The tracer, one offset update per two words, sets this rate.
//   When m_tready is low the output register holds its word and the tracer
//   waits; centers keep queueing until the queue is full.
//   Reset empties the queue, stops any trace and restores radius 20.
module midpoint_circle_outline_top import mco_pkg::*; #(
	parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        radius_we,
	input  logic [RAD_W-1:0]            radius_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,   // center_x, center_y
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [((8*COORD_BITS+7)/8)*8-1:0] m_tdata,   // px0,py0,px1,py1,px2,py2,px3,py3
	output logic [0:0]                  m_tuser,         // swapped_half
	output logic                        m_tlast
);

	localparam int unsigned OFF_BITS = $clog2(MAX_RADIUS + 2);
	localparam int unsigned JOB_W    = 2 * COORD_BITS + OFF_BITS;
	localparam int unsigned OUT_W    = ((8*COORD_BITS+7)/8)*8;
	localparam int unsigned PTS_W    = 8 * COORD_BITS;

	logic                job_valid;
	logic                job_pop;
	logic [JOB_W-1:0]    job_data;
	logic [PTS_W-1:0]    points;
	logic                swapped;

	// Intake and job queue
	mco_front #(
		.MAX_RADIUS (MAX_RADIUS),
		.COORD_BITS (COORD_BITS),
		.OFF_BITS   (OFF_BITS),
		.JOB_W      (JOB_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.radius_we    (radius_we),
		.radius_wdata (radius_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_cx        (s_tdata[COORD_BITS-1:0]),
		.in_cy        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.job_valid    (job_valid),
		.job_pop      (job_pop),
		.job_data     (job_data)
	);

	// Tracer and output register
	mco_back #(
		.MAX_RADIUS (MAX_RADIUS),
		.COORD_BITS (COORD_BITS),
		.OFF_BITS   (OFF_BITS),
		.JOB_W      (JOB_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_pop     (job_pop),
		.job_data    (job_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_points  (points),
		.out_swapped (swapped),
		.out_last    (m_tlast)
	);

	assign m_tdata    = OUT_W'(points);
	assign m_tuser[0] = swapped;

endmodule
